>>> sv/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// implication or plain property checked on every clock edge outside reset
`define ARA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen on a clock edge outside reset
`define ARA_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ARA_ASSERT(label, prop, msg)
`define ARA_NEVER(label, expr, msg)
`endif
`endif

>>> sv/ara_pkg.sv
// types and constants of the address region allocator
package ara_pkg;

	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_CREATE = 2'd1,
		CMD_FREE   = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NOFIT   = 2'd1,
		STS_NOSPARE = 2'd2,
		STS_INVALID = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_DECIDE,
		S_INIT_WR,
		S_COPY_RD,
		S_COPY_EV,
		S_COPY_WR,
		S_REPLY
	} state_t;

	localparam logic [1:0] CFG_USER_BASE    = 2'd0;
	localparam logic [1:0] CFG_USER_CEILING = 2'd1;
	localparam logic [1:0] CFG_PAGE_SHIFT   = 2'd2;

	localparam logic [31:0] USER_BASE_RST    = 32'h0000_1000;
	localparam logic [31:0] USER_CEILING_RST = 32'h8000_0000;
	localparam logic [4:0]  PAGE_SHIFT_RST   = 5'd12;

endpackage

>>> sv/ara_ram.sv
// generic single write port ram with registered read
module ara_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/address_region_allocator_core.sv
// top level of the address region allocator: sequencer, scan unit and table ram
//
// usage: a command is transferred when start is high and busy is low; the
// fields cmd, req_addr, req_size, fixed_place, map_flags and kind_in are
// sampled on that edge. busy stays high until the result has been shown.
// each command yields one result, shown for one cycle with done high on
// status, found_base, found_ceiling, found_kind and found_flags; the
// receiver cannot stall it. configuration registers are written through
// cfg_we / cfg_idx / cfg_wdata; the user must do so only while the block
// is idle, which the block does not enforce. the region table is kept
// address ordered in one ram holding two banks; a command reads the table
// one entry at a time, a read state then an evaluate state per entry,
// through the scan compare unit, then a table edit copies it into the
// other bank. init writes one entry without a scan; find scans the table;
// create or free scans it and, unless refused, copies it, writing w
// entries where w is at most n+2 for n regions in the table.
// reset empties the table and loads the default user range and page size;
// no clearing pass is needed.
`include "assert_macros.svh"

module address_region_allocator_core import ara_pkg::*; #(
	parameter int REGION_SLOTS = 64,
	parameter int ADDR_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] req_addr,
	input  logic [31:0] req_size,
	input  logic        fixed_place,
	input  logic [31:0] map_flags,
	input  logic [3:0]  kind_in,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_base,
	output logic [31:0] found_ceiling,
	output logic [3:0]  found_kind,
	output logic [31:0] found_flags,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int AW        = ADDR_BITS;
	// wide sums keep the carry so overflowing ranges never fit
	localparam int SW        = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
	localparam int IW        = $clog2(REGION_SLOTS);
	localparam int CW        = $clog2(REGION_SLOTS + 1);
	localparam int RAW       = IW + 1;
	localparam int RAM_DEPTH = 2 << IW;
	localparam int EW        = 2 * AW + 36;

	// sequencer state
	state_t state_q, state_d;

	// configuration
	logic [31:0] ubase_q, uceil_q;
	logic [4:0]  pshift_q;

	// latched command
	cmd_t        cmd_q;
	logic [AW-1:0] addr_q;
	logic [31:0] size_q;
	logic        fixed_q;
	logic [31:0] flags_q;
	logic [3:0]  kind_q;
	logic [SW-1:0] end_q, pm_q;

	// table bookkeeping
	logic [CW-1:0] n_q, k_q, wcnt_q;
	logic          cur_q;
	logic          k_last;

	// ram port
	logic           ram_we;
	logic [RAW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0]  ram_wdata, ram_rdata;

	// entry just read
	logic [AW-1:0] rb, rc;
	logic [3:0]    rk;
	logic [31:0]   rf;

	// scan records
	logic          a_hit_q, e_hit_q, e_pend_q, en_valid_q, f_hit_q, pv_valid_q, ap_valid_q;
	logic [AW-1:0] a_base_q, a_ceil_q, ap_base_q, e_ceil_q, en_ceil_q;
	logic [AW-1:0] f_base_q, f_ceil_q, f_al_q, pv_base_q;
	logic [3:0]    a_kind_q, ap_kind_q, e_kind_q, en_kind_q, pv_kind_q;
	logic [31:0]   a_flags_q;
	logic [SW-1:0] f_end_q;

	// scan compare unit
	logic [SW-1:0] sw_b, sw_c, al;
	logic          in_a, in_e, fit;

	// decision
	status_t       d_status;
	logic          d_init, d_modify;
	logic [AW-1:0] d_base, d_ceil, d_x, d_y;
	logic [3:0]    d_kind;
	logic [31:0]   d_flags;
	logic [2:0]    d_ins_en;
	logic [AW-1:0] d_ins_base [3];
	logic [AW-1:0] d_ins_ceil [3];
	logic [3:0]    d_ins_kind [3];
	logic [31:0]   d_ins_flags [3];

	// result registers
	status_t       res_status_q;
	logic [AW-1:0] res_base_q, res_ceil_q;
	logic [3:0]    res_kind_q;
	logic [31:0]   res_flags_q;

	// table edit: range [x,y) replaced by up to three inserted entries
	logic [AW-1:0] x_q, y_q;
	logic [2:0]    ins_en_q;
	logic [AW-1:0] ins_base_q [3];
	logic [AW-1:0] ins_ceil_q [3];
	logic [3:0]    ins_kind_q [3];
	logic [31:0]   ins_flags_q [3];
	logic          ins_done_q;
	logic [4:0]    mask_q, mask_d, mask_clr;
	logic          overlap;
	logic [AW-1:0] eb_q, ec_q;
	logic [3:0]    ek_q;
	logic [31:0]   ef_q;
	logic [2:0]    sel;
	logic [AW-1:0] it_base, it_ceil;
	logic [3:0]    it_kind;
	logic [31:0]   it_flags;

	ara_ram #(
		.WIDTH (EW),
		.DEPTH (RAM_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rb = ram_rdata[AW-1:0];
	assign rc = ram_rdata[2*AW-1:AW];
	assign rk = ram_rdata[2*AW+3:2*AW];
	assign rf = ram_rdata[EW-1:2*AW+4];

	assign k_last = (k_q == n_q - CW'(1));

	// scan compare: containment of addr and of the last byte, first fit test
	always_comb begin
		sw_b = SW'(rb);
		sw_c = SW'(rc);
		al   = (sw_b + pm_q) & ~pm_q;
		in_a = (rb <= addr_q) && (addr_q < rc);
		in_e = (sw_b < end_q) && (end_q <= sw_c);
		fit  = (rk == 4'd0) && (al < sw_c) && (SW'(size_q) <= sw_c - al);
	end

	// command decision after the scan
	always_comb begin
		logic          fit_ok;
		logic [AW-1:0] r_base, r_ceil, nb, ne, lo, hi, ub, uc;
		logic [SW-1:0] ne_w;
		logic [1:0]    needs;
		d_status = STS_OK;
		d_init   = 1'b0;
		d_modify = 1'b0;
		d_base   = a_base_q;
		d_ceil   = a_ceil_q;
		d_kind   = a_kind_q;
		d_flags  = a_flags_q;
		d_x      = '0;
		d_y      = '0;
		d_ins_en = '0;
		for (int j = 0; j < 3; j++) begin
			d_ins_base[j]  = '0;
			d_ins_ceil[j]  = '0;
			d_ins_kind[j]  = '0;
			d_ins_flags[j] = '0;
		end
		ub     = AW'(ubase_q);
		uc     = AW'(uceil_q);
		fit_ok = fixed_q ? (a_hit_q && (a_kind_q == 4'd0) && (end_q <= SW'(a_ceil_q)))
		                 : f_hit_q;
		r_base = fixed_q ? a_base_q : f_base_q;
		r_ceil = fixed_q ? a_ceil_q : f_ceil_q;
		nb     = fixed_q ? addr_q : f_al_q;
		ne_w   = fixed_q ? end_q : f_end_q;
		ne     = AW'(ne_w);
		needs  = {1'b0, addr_q != a_base_q} + {1'b0, end_q < SW'(e_ceil_q)};
		// merged free range: absorb a free neighbor on either side
		if (addr_q != a_base_q) begin
			lo = (a_kind_q == 4'd0) ? a_base_q : addr_q;
		end else begin
			lo = (ap_valid_q && ap_kind_q == 4'd0) ? ap_base_q : addr_q;
		end
		if (end_q < SW'(e_ceil_q)) begin
			hi = (e_kind_q == 4'd0) ? e_ceil_q : AW'(end_q);
		end else begin
			hi = (en_valid_q && en_kind_q == 4'd0) ? en_ceil_q : AW'(end_q);
		end
		case (cmd_q)
			CMD_INIT: begin
				if (uc <= ub) begin
					d_status = STS_INVALID;
				end else begin
					d_init  = 1'b1;
					d_base  = ub;
					d_ceil  = uc;
					d_kind  = 4'd0;
					d_flags = '0;
				end
			end
			CMD_CREATE: begin
				if (kind_q == 4'd0 || size_q == 32'd0) begin
					d_status = STS_INVALID;
				end else if (!fit_ok) begin
					d_status = STS_NOFIT;
				end else if (n_q > CW'(REGION_SLOTS - 2)) begin
					d_status = STS_NOSPARE;
				end else begin
					d_modify       = 1'b1;
					d_x            = r_base;
					d_y            = r_ceil;
					d_ins_en       = {ne < r_ceil, 1'b1, r_base < nb};
					d_ins_base[0]  = r_base;
					d_ins_ceil[0]  = nb;
					d_ins_base[1]  = nb;
					d_ins_ceil[1]  = ne;
					d_ins_kind[1]  = kind_q;
					d_ins_flags[1] = flags_q;
					d_ins_base[2]  = ne;
					d_ins_ceil[2]  = r_ceil;
					d_base         = nb;
					d_ceil         = ne;
					d_kind         = kind_q;
					d_flags        = flags_q;
				end
			end
			CMD_FREE: begin
				if (size_q == 32'd0 || !a_hit_q || !e_hit_q) begin
					d_status = STS_INVALID;
				end else if ({1'b0, n_q} + (CW+1)'(needs) > (CW+1)'(REGION_SLOTS)) begin
					d_status = STS_NOSPARE;
				end else begin
					d_modify      = 1'b1;
					d_x           = lo;
					d_y           = hi;
					d_ins_en      = 3'b010;
					d_ins_base[1] = lo;
					d_ins_ceil[1] = hi;
					d_base        = lo;
					d_ceil        = hi;
					d_kind        = 4'd0;
					d_flags       = '0;
				end
			end
			CMD_FIND: begin
				if (!a_hit_q) begin
					d_status = STS_INVALID;
				end
			end
			default: begin
				d_status = STS_INVALID;
			end
		endcase
		if (d_status != STS_OK) begin
			d_base  = '0;
			d_ceil  = '0;
			d_kind  = '0;
			d_flags = '0;
		end
	end

	// copy: split one old entry into head piece, inserts and tail piece
	always_comb begin
		overlap = (rc > x_q) && (rb < y_q);
		mask_d  = {rc > y_q,
		           ins_en_q & {3{overlap && !ins_done_q}},
		           rb < x_q};
		sel = 3'd0;
		for (int j = 4; j >= 0; j--) begin
			if (mask_q[j]) begin
				sel = 3'(j);
			end
		end
		mask_clr = mask_q & ~(5'b00001 << sel);
		it_base  = eb_q;
		it_ceil  = (ec_q < x_q) ? ec_q : x_q;
		it_kind  = ek_q;
		it_flags = ef_q;
		case (sel)
			3'd1: begin
				it_base  = ins_base_q[0];
				it_ceil  = ins_ceil_q[0];
				it_kind  = ins_kind_q[0];
				it_flags = ins_flags_q[0];
			end
			3'd2: begin
				it_base  = ins_base_q[1];
				it_ceil  = ins_ceil_q[1];
				it_kind  = ins_kind_q[1];
				it_flags = ins_flags_q[1];
			end
			3'd3: begin
				it_base  = ins_base_q[2];
				it_ceil  = ins_ceil_q[2];
				it_kind  = ins_kind_q[2];
				it_flags = ins_flags_q[2];
			end
			3'd4: begin
				it_base = (eb_q > y_q) ? eb_q : y_q;
				it_ceil = ec_q;
			end
			default: begin
				it_base = eb_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cmd_t'(cmd) == CMD_INIT || n_q == '0) ? S_DECIDE : S_SCAN_RD;
				end
			end
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: state_d = k_last ? S_DECIDE : S_SCAN_RD;
			S_DECIDE: begin
				if (d_init) begin
					state_d = S_INIT_WR;
				end else if (d_modify) begin
					state_d = S_COPY_RD;
				end else begin
					state_d = S_REPLY;
				end
			end
			S_INIT_WR: state_d = S_REPLY;
			S_COPY_RD: state_d = S_COPY_EV;
			S_COPY_EV: state_d = S_COPY_WR;
			S_COPY_WR: begin
				if (mask_q == '0) begin
					state_d = k_last ? S_REPLY : S_COPY_RD;
				end
			end
			S_REPLY: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy      = (state_q != S_IDLE);
		done      = (state_q == S_REPLY);
		ram_raddr = {cur_q, k_q[IW-1:0]};
		ram_we    = 1'b0;
		ram_waddr = {~cur_q, wcnt_q[IW-1:0]};
		ram_wdata = {it_flags, it_kind, it_ceil, it_base};
		case (state_q)
			S_INIT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q, IW'(0)};
				ram_wdata = {32'd0, 4'd0, res_ceil_q, res_base_q};
			end
			S_COPY_WR: begin
				ram_we = (mask_q != '0);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ubase_q    <= USER_BASE_RST;
			uceil_q    <= USER_CEILING_RST;
			pshift_q   <= PAGE_SHIFT_RST;
			n_q        <= '0;
			cur_q      <= 1'b0;
			k_q        <= '0;
			wcnt_q     <= '0;
			mask_q     <= '0;
			ins_done_q <= 1'b0;
			a_hit_q    <= 1'b0;
			e_hit_q    <= 1'b0;
			e_pend_q   <= 1'b0;
			en_valid_q <= 1'b0;
			f_hit_q    <= 1'b0;
			pv_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_USER_BASE:    ubase_q  <= cfg_wdata;
					CFG_USER_CEILING: uceil_q  <= cfg_wdata;
					CFG_PAGE_SHIFT:   pshift_q <= cfg_wdata[4:0];
					default:          ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q        <= '0;
						a_hit_q    <= 1'b0;
						e_hit_q    <= 1'b0;
						e_pend_q   <= 1'b0;
						en_valid_q <= 1'b0;
						f_hit_q    <= 1'b0;
						pv_valid_q <= 1'b0;
					end
				end
				S_SCAN_EV: begin
					if (in_a) a_hit_q <= 1'b1;
					if (in_e) e_hit_q <= 1'b1;
					if (e_pend_q) en_valid_q <= 1'b1;
					if (fit) f_hit_q <= 1'b1;
					e_pend_q   <= in_e;
					pv_valid_q <= 1'b1;
					k_q        <= k_q + CW'(1);
				end
				S_DECIDE: begin
					k_q        <= '0;
					wcnt_q     <= '0;
					ins_done_q <= 1'b0;
					if (d_init) begin
						n_q <= CW'(1);
					end else if (cmd_q == CMD_INIT) begin
						n_q <= '0;
					end
				end
				S_COPY_EV: begin
					mask_q <= mask_d;
					if (overlap) ins_done_q <= 1'b1;
				end
				S_COPY_WR: begin
					if (mask_q != '0) begin
						mask_q <= mask_clr;
						wcnt_q <= wcnt_q + CW'(1);
					end else if (k_last) begin
						cur_q <= ~cur_q;
						n_q   <= wcnt_q;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q   <= cmd_t'(cmd);
					addr_q  <= AW'(req_addr);
					size_q  <= req_size;
					fixed_q <= fixed_place;
					flags_q <= map_flags;
					kind_q  <= kind_in;
					end_q   <= SW'(AW'(req_addr)) + SW'(req_size);
					pm_q    <= (SW'(1) << pshift_q) - SW'(1);
				end
			end
			S_SCAN_EV: begin
				if (in_a) begin
					a_base_q   <= rb;
					a_ceil_q   <= rc;
					a_kind_q   <= rk;
					a_flags_q  <= rf;
					ap_valid_q <= pv_valid_q;
					ap_base_q  <= pv_base_q;
					ap_kind_q  <= pv_kind_q;
				end
				if (in_e) begin
					e_ceil_q <= rc;
					e_kind_q <= rk;
				end
				if (e_pend_q) begin
					en_ceil_q <= rc;
					en_kind_q <= rk;
				end
				if (fit && !f_hit_q) begin
					f_base_q <= rb;
					f_ceil_q <= rc;
					f_al_q   <= AW'(al);
					f_end_q  <= al + SW'(size_q);
				end
				pv_base_q <= rb;
				pv_kind_q <= rk;
			end
			S_DECIDE: begin
				res_status_q <= d_status;
				res_base_q   <= d_base;
				res_ceil_q   <= d_ceil;
				res_kind_q   <= d_kind;
				res_flags_q  <= d_flags;
				x_q          <= d_x;
				y_q          <= d_y;
				ins_en_q     <= d_ins_en;
				for (int j = 0; j < 3; j++) begin
					ins_base_q[j]  <= d_ins_base[j];
					ins_ceil_q[j]  <= d_ins_ceil[j];
					ins_kind_q[j]  <= d_ins_kind[j];
					ins_flags_q[j] <= d_ins_flags[j];
				end
			end
			S_COPY_EV: begin
				eb_q <= rb;
				ec_q <= rc;
				ek_q <= rk;
				ef_q <= rf;
			end
			default: ;
		endcase
	end

	assign status        = res_status_q;
	assign found_base    = 32'(res_base_q);
	assign found_ceiling = 32'(res_ceil_q);
	assign found_kind    = res_kind_q;
	assign found_flags   = res_flags_q;

	`ARA_ASSERT(a_done_pulse, done |=> !done, "result strobe held longer than one cycle")
	`ARA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "command transfer did not raise busy")
	`ARA_NEVER(a_count_range, n_q > CW'(REGION_SLOTS), "region count above slot count")
	`ARA_NEVER(a_write_range, (state_q == S_COPY_WR) && ram_we && (wcnt_q >= CW'(REGION_SLOTS)), "table copy overflows bank")
	`ARA_ASSERT(a_err_zero, (done && (res_status_q != STS_OK)) |-> ((res_base_q == '0) && (res_kind_q == '0) && (res_flags_q == '0)), "error result with nonzero fields")

endmodule

>>> verif/tb.sv
// self-checking testbench for the address region allocator core
module tb;
	import ara_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         NSLOT = 64;
	localparam logic [6:0] NIL   = 7'd64;
	// idle cycles with no transfer at all before the run is called hung
	localparam int         WATCHDOG_LIMIT = 20000;

	// one command as driven on the request ports
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] addr;
		logic [31:0] size;
		logic        fixed;
		logic [31:0] flags;
		logic [3:0]  kind;
	} req_t;

	// one result as shown with done
	typedef struct packed {
		status_t     st;
		logic [31:0] base;
		logic [31:0] ceil;
		logic [3:0]  kind;
		logic [31:0] flags;
	} reply_t;

	// directed row: typed marks a reply written out by hand
	typedef struct packed {
		req_t   rq;
		logic   typed;
		reply_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = '0;
	logic [31:0] req_addr = '0;
	logic [31:0] req_size = '0;
	logic        fixed_place = 1'b0;
	logic [31:0] map_flags = '0;
	logic [3:0]  kind_in = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] found_base;
	logic [31:0] found_ceiling;
	logic [3:0]  found_kind;
	logic [31:0] found_flags;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;

	address_region_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .req_addr(req_addr), .req_size(req_size),
		.fixed_place(fixed_place), .map_flags(map_flags), .kind_in(kind_in),
		.done(done), .status(status), .found_base(found_base),
		.found_ceiling(found_ceiling), .found_kind(found_kind),
		.found_flags(found_flags),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// region table mirror: address ordered list plus spare pool
	// ------------------------------------------------------------------
	logic [63:0] rg_base  [NSLOT];
	logic [63:0] rg_ceil  [NSLOT];
	logic [3:0]  rg_kind  [NSLOT];
	logic [31:0] rg_flags [NSLOT];
	logic [6:0]  rg_next  [NSLOT];
	logic [6:0]  rg_prev  [NSLOT];
	logic [6:0]  order_head;
	logic [6:0]  pool_head;
	logic [63:0] cur_base;
	logic [63:0] cur_ceil;
	logic [4:0]  cur_shift;

	reply_t      pending_q[$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          no_idle = 1'b0;

	function automatic bit live(logic [6:0] s);
		return s < NIL;
	endfunction

	function automatic void mirror_reset();
		for (int k = 0; k < NSLOT; k++) begin
			rg_base[k] = '0;
			rg_ceil[k] = '0;
			rg_kind[k] = '0;
			rg_flags[k] = '0;
			rg_next[k] = 7'(k + 1);
			rg_prev[k] = NIL;
		end
		order_head = NIL;
		pool_head = '0;
		cur_base = 64'h1000;
		cur_ceil = 64'h8000_0000;
		cur_shift = 5'd12;
	endfunction

	function automatic logic [6:0] holder(logic [63:0] a);
		logic [6:0] i;
		i = order_head;
		for (int g = 0; g < NSLOT && live(i); g++) begin
			if (rg_base[i] <= a && a < rg_ceil[i])
				return i;
			i = rg_next[i];
		end
		return NIL;
	endfunction

	function automatic bit pool_has(int n);
		logic [6:0] s;
		int c;
		s = pool_head;
		c = 0;
		for (int g = 0; g < NSLOT && c < n && live(s); g++) begin
			c++;
			s = rg_next[s];
		end
		return c >= n;
	endfunction

	function automatic logic [6:0] pool_take();
		logic [6:0] s;
		s = pool_head;
		pool_head = rg_next[s];
		rg_next[s] = NIL;
		rg_prev[s] = NIL;
		return s;
	endfunction

	function automatic void pool_give(logic [6:0] s);
		rg_next[s] = pool_head;
		rg_prev[s] = NIL;
		pool_head = s;
	endfunction

	function automatic void link_after(logic [6:0] at, logic [6:0] s);
		logic [6:0] n;
		n = rg_next[at];
		rg_prev[s] = at;
		rg_next[s] = n;
		if (live(n))
			rg_prev[n] = s;
		rg_next[at] = s;
	endfunction

	function automatic void link_before(logic [6:0] at, logic [6:0] s);
		logic [6:0] p;
		p = rg_prev[at];
		rg_next[s] = at;
		rg_prev[s] = p;
		if (live(p))
			rg_next[p] = s;
		else
			order_head = s;
		rg_prev[at] = s;
	endfunction

	function automatic void unlink(logic [6:0] s);
		logic [6:0] p, n;
		p = rg_prev[s];
		n = rg_next[s];
		if (live(p))
			rg_next[p] = n;
		else
			order_head = n;
		if (live(n))
			rg_prev[n] = p;
	endfunction

	function automatic int cut_needed(logic [63:0] a);
		logic [6:0] i;
		i = holder(a);
		return (live(i) && a != rg_base[i]) ? 1 : 0;
	endfunction

	// split the region holding a so that a becomes a region base
	function automatic void cut_at(logic [63:0] a);
		logic [6:0] i, s;
		i = holder(a);
		if (!live(i) || a == rg_base[i] || !live(pool_head))
			return;
		s = pool_take();
		link_after(i, s);
		rg_base[s] = a;
		rg_ceil[s] = rg_ceil[i];
		rg_kind[s] = rg_kind[i];
		rg_flags[s] = rg_flags[i];
		rg_ceil[i] = a;
	endfunction

	function automatic void fold_into_prev(logic [6:0] i);
		logic [6:0] p;
		p = rg_prev[i];
		rg_ceil[p] = rg_ceil[i];
		unlink(i);
		pool_give(i);
	endfunction

	function automatic reply_t report(status_t st, logic [6:0] i);
		reply_t r;
		r = '{st: st, default: '0};
		if (st == STS_OK && live(i)) begin
			r.base = rg_base[i][31:0];
			r.ceil = rg_ceil[i][31:0];
			r.kind = rg_kind[i];
			r.flags = rg_flags[i];
		end
		return r;
	endfunction

	// expected reply of one command, updating the mirror as the block would
	function automatic reply_t region_reply(req_t rq);
		logic [63:0] addr, size, last, pm, al;
		logic [6:0]  i, j, s, n, p;
		addr = {32'b0, rq.addr};
		size = {32'b0, rq.size};
		i = NIL;
		case (rq.cmd)
			CMD_INIT: begin
				for (int g = 0; g < NSLOT && live(order_head); g++) begin
					s = order_head;
					order_head = rg_next[s];
					pool_give(s);
				end
				order_head = NIL;
				if (cur_ceil <= cur_base)
					return report(STS_INVALID, NIL);
				if (!live(pool_head))
					return report(STS_NOSPARE, NIL);
				s = pool_take();
				order_head = s;
				rg_base[s] = cur_base;
				rg_ceil[s] = cur_ceil;
				rg_kind[s] = '0;
				rg_flags[s] = '0;
				return report(STS_OK, s);
			end
			CMD_CREATE: begin
				if (rq.kind == 0 || size == 0)
					return report(STS_INVALID, NIL);
				if (rq.fixed) begin
					last = addr + size;
					i = holder(addr);
					if (!live(i) || rg_kind[i] != 0 || last > rg_ceil[i])
						return report(STS_NOFIT, NIL);
				end else begin
					// first fit walks in address order
					pm = (64'd1 << cur_shift) - 64'd1;
					j = order_head;
					for (int g = 0; g < NSLOT && live(j); g++) begin
						al = (rg_base[j] + pm) & ~pm;
						if (rg_kind[j] == 0 && al >= rg_base[j] && al < rg_ceil[j] &&
								size <= rg_ceil[j] - al) begin
							i = j;
							addr = al;
							break;
						end
						j = rg_next[j];
					end
					if (!live(i))
						return report(STS_NOFIT, NIL);
					last = addr + size;
				end
				if (!pool_has(2))
					return report(STS_NOSPARE, NIL);
				if (rg_base[i] < addr) begin
					s = pool_take();
					link_before(i, s);
					rg_base[s] = rg_base[i];
					rg_ceil[s] = addr;
					rg_kind[s] = '0;
					rg_flags[s] = '0;
				end
				if (last < rg_ceil[i]) begin
					s = pool_take();
					link_after(i, s);
					rg_base[s] = last;
					rg_ceil[s] = rg_ceil[i];
					rg_kind[s] = '0;
					rg_flags[s] = '0;
				end
				rg_base[i] = addr;
				rg_ceil[i] = last;
				rg_kind[i] = rq.kind;
				rg_flags[i] = rq.flags;
				return report(STS_OK, i);
			end
			CMD_FREE: begin
				last = addr + size;
				if (size == 0 || !live(holder(addr)) || !live(holder(last - 64'd1)))
					return report(STS_INVALID, NIL);
				if (!pool_has(cut_needed(addr) + cut_needed(last)))
					return report(STS_NOSPARE, NIL);
				cut_at(addr);
				cut_at(last);
				i = holder(addr);
				for (int g = 0; g < NSLOT && live(i) && rg_base[i] < last; g++) begin
					n = rg_next[i];
					p = rg_prev[i];
					if (live(p) && rg_kind[p] == 0)
						fold_into_prev(i);
					else begin
						rg_kind[i] = '0;
						rg_flags[i] = '0;
					end
					i = n;
				end
				if (live(i) && rg_kind[i] == 0) begin
					p = rg_prev[i];
					if (live(p) && rg_kind[p] == 0)
						fold_into_prev(i);
				end
				return report(STS_OK, holder(addr));
			end
			default: begin
				i = holder(addr);
				return report(live(i) ? STS_OK : STS_INVALID, i);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result checker and watchdog, both sampled on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: st=%0d base=%h", status, found_base);
			end else begin
				want = pending_q.pop_front();
				if (status !== want.st || found_base !== want.base ||
						found_ceiling !== want.ceil || found_kind !== want.kind ||
						found_flags !== want.flags) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d %h..%h k=%h f=%h got st=%0d %h..%h k=%h f=%h",
							want.st, want.base, want.ceil, want.kind, want.flags,
							status, found_base, found_ceiling, found_kind, found_flags);
				end
			end
		end
		// any transfer in either direction keeps the watchdog quiet
		if (!arst_n || done || (start && !busy))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------
	// stimulus side
	// ------------------------------------------------------------------
	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	// hold the command until the block takes it, then at times idle for a while
	task automatic issue(req_t rq, logic typed, reply_t want);
		reply_t got;
		int gap;
		if (!start)
			start <= 1'b1;
		cmd <= rq.cmd;
		req_addr <= rq.addr;
		req_size <= rq.size;
		fixed_place <= rq.fixed;
		map_flags <= rq.flags;
		kind_in <= rq.kind;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		// transfer happened on this edge
		got = region_reply(rq);
		pending_q.push_back(typed ? want : got);
		gap = idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop start and wait until every reply is back and the block is idle
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_q.size() != 0 || busy !== 1'b0);
	endtask

	task automatic set_range(logic [31:0] b, logic [31:0] c, logic [4:0] sh);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_USER_BASE;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_idx <= CFG_USER_CEILING;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_idx <= CFG_PAGE_SHIFT;
		cfg_wdata <= {27'b0, sh};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_base = {32'b0, b};
		cur_ceil = {32'b0, c};
		cur_shift = sh;
	endtask

	// mostly an address inside some region of the table, at times any address
	function automatic logic [31:0] pick_addr();
		logic [6:0]  i;
		logic [63:0] span;
		int n, k;
		n = 0;
		i = order_head;
		for (int g = 0; g < NSLOT && live(i); g++) begin
			n++;
			i = rg_next[i];
		end
		if (n == 0 || $urandom_range(0, 7) == 0)
			return $urandom;
		k = $urandom_range(0, n - 1);
		i = order_head;
		for (int g = 0; g < k; g++)
			i = rg_next[i];
		if ($urandom_range(0, 2) == 0)
			return rg_base[i][31:0];
		span = rg_ceil[i] - rg_base[i];
		return 32'(rg_base[i] + ({32'b0, $urandom} % span));
	endfunction

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return '0;
		if (r < 12)
			return $urandom;
		if (r < 55)
			return $urandom_range(1, 64);
		return $urandom_range(1, 32'd1 << (cur_shift + 3));
	endfunction

	function automatic req_t random_req(bit crowd);
		req_t rq;
		int r;
		rq.addr = pick_addr();
		rq.size = pick_size();
		rq.fixed = 1'($urandom_range(0, 1));
		rq.flags = $urandom;
		rq.kind = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		r = $urandom_range(0, 99);
		// crowded phases lean on create to run the spare pool dry
		if (r < 3)
			rq.cmd = CMD_INIT;
		else if (r < (crowd ? 70 : 45))
			rq.cmd = CMD_CREATE;
		else if (r < (crowd ? 85 : 75))
			rq.cmd = CMD_FREE;
		else
			rq.cmd = CMD_FIND;
		return rq;
	endfunction

	// directed rows on the reset range 0x1000..0x8000_0000, page 4 KiB
	localparam reply_t NONE_INV = '{st: STS_INVALID, default: '0};
	localparam reply_t NONE_FIT = '{st: STS_NOFIT, default: '0};
	localparam reply_t WHOLE    = '{STS_OK, 32'h1000, 32'h8000_0000, 4'h0, 32'h0};
	localparam reply_t ANY      = '{st: STS_OK, default: '0};
	localparam row_t ROWS [22] = '{
		// lookup on the empty table after reset
		'{'{CMD_FIND,   32'h0000_1000, 32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, NONE_INV},
		'{'{CMD_INIT,   32'h0,         32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, WHOLE},
		'{'{CMD_FIND,   32'h0,         32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, NONE_INV},
		'{'{CMD_FIND,   32'h0000_1000, 32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, WHOLE},
		'{'{CMD_FIND,   32'h7fff_ffff, 32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, WHOLE},
		'{'{CMD_FIND,   32'hffff_ffff, 32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, NONE_INV},
		// zero kind and zero size are refused
		'{'{CMD_CREATE, 32'h0000_2000, 32'h10,        1'b1, 32'h1,         4'h0}, 1'b1, NONE_INV},
		'{'{CMD_CREATE, 32'h0000_2000, 32'h0,         1'b1, 32'h1,         4'h3}, 1'b1, NONE_INV},
		'{'{CMD_CREATE, 32'h0,         32'h1000,      1'b0, 32'hffff_ffff, 4'hf}, 1'b1,
			'{STS_OK, 32'h1000, 32'h2000, 4'hf, 32'hffff_ffff}},
		'{'{CMD_CREATE, 32'h0000_5000, 32'h123,       1'b1, 32'ha5a5_a5a5, 4'h1}, 1'b0, ANY},
		// fixed place on a used region, off the table, and no first fit
		'{'{CMD_CREATE, 32'h0000_5000, 32'h10,        1'b1, 32'h0,         4'h2}, 1'b1, NONE_FIT},
		'{'{CMD_CREATE, 32'hffff_ff00, 32'h200,       1'b1, 32'h0,         4'h2}, 1'b1, NONE_FIT},
		'{'{CMD_CREATE, 32'h0,         32'hffff_ffff, 1'b0, 32'h0,         4'h2}, 1'b1, NONE_FIT},
		// free with bad ranges, then a valid free inside a created region
		'{'{CMD_FREE,   32'h0000_3000, 32'h0,         1'b0, 32'h0,         4'h1}, 1'b1, NONE_INV},
		'{'{CMD_FREE,   32'h0,         32'h10,        1'b0, 32'h0,         4'h1}, 1'b1, NONE_INV},
		'{'{CMD_FREE,   32'h0000_5080, 32'h10,        1'b0, 32'h0,         4'h1}, 1'b0, ANY},
		// range ending right at the top is fine, one byte more is not
		'{'{CMD_FREE,   32'h7fff_f000, 32'h1000,      1'b0, 32'h0,         4'h1}, 1'b0, ANY},
		'{'{CMD_FREE,   32'h7fff_f000, 32'h1001,      1'b0, 32'h0,         4'h1}, 1'b1, NONE_INV},
		// freeing everything coalesces back to one region
		'{'{CMD_FREE,   32'h0000_1000, 32'h7fff_f000, 1'b0, 32'h0,         4'h1}, 1'b1, WHOLE},
		'{'{CMD_CREATE, 32'h7fff_ffff, 32'h1,         1'b1, 32'h5a5a_5a5a, 4'h7}, 1'b0, ANY},
		'{'{CMD_FIND,   32'h7fff_ffff, 32'h0,         1'b0, 32'h0,         4'h1}, 1'b0, ANY},
		'{'{CMD_INIT,   32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 4'hf}, 1'b1, WHOLE}
	};

	initial begin
		req_t        rq;
		logic [31:0] b, c;
		logic [4:0]  sh;
		mirror_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (ROWS[k])
			issue(ROWS[k].rq, ROWS[k].typed, ROWS[k].want);
		// the sender holds off here until every reply is in
		settle();

		for (int ph = 0; ph < 11; ph++) begin
			case (ph % 7)
				0: begin b = 32'h1000;      c = 32'h8000_0000; sh = 5'd12; end
				1: begin b = 32'h0;         c = 32'hffff_ffff; sh = 5'd0;  end
				2: begin b = 32'h1_0000;    c = 32'h2_0000;    sh = 5'd4;  end
				3: begin b = 32'hffff_0000; c = 32'hffff_ffff; sh = 5'd20; end
				// empty user range: init is refused and the table stays empty
				4: begin b = 32'h100;       c = 32'h100;       sh = 5'd15; end
				5: begin b = 32'h1234;      c = 32'h4_0000;    sh = 5'd8;  end
				default: begin
					b = $urandom;
					c = $urandom;
					if (c < b) begin
						b = b ^ c;
						c = b ^ c;
						b = b ^ c;
					end
					sh = 5'($urandom_range(0, 20));
				end
			endcase
			set_range(b, c, sh);
			no_idle = ($urandom_range(0, 3) == 0);
			rq = '{cmd: CMD_INIT, default: '0};
			issue(rq, 1'b0, ANY);
			for (int n = 0; n < 100; n++)
				issue(random_req(ph % 7 == 2 || ph % 7 == 5), 1'b0, ANY);
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
